>>> rtl/ocew_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPL capture event window - shared package
// Types, register map codes and constants used by the non-RAM block files.
// ----------------------------------------------------------------------------
package ocew_pkg;

    // Code map geometry
    localparam int MAP_ENTRIES_DEF = 128;
    localparam int MAP_IDX_W       = 7;     // code bits that index the map

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_SHORT_DELAY  = 2'd0,
        REG_LONG_DELAY   = 2'd1,
        REG_WINDOW_START = 2'd2,
        REG_WINDOW_END   = 2'd3
    } cfg_reg_idx_t;

    // Reset values of the configuration registers
    localparam logic [7:0]  SHORT_DELAY_RST  = 8'h00;
    localparam logic [7:0]  LONG_DELAY_RST   = 8'h01;
    localparam logic [31:0] WINDOW_START_RST = 32'h0000_0000;
    localparam logic [31:0] WINDOW_END_RST   = 32'hFFFF_FFFF;

    // Decode constants
    localparam logic [3:0] KEY_REG_NIBBLE = 4'hB;   // registers 0xB0-0xBF
    localparam int         KEY_ON_BIT     = 5;
    localparam logic       CMD_LOAD       = 1'b0;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  short_delay_code;
        logic [7:0]  long_delay_code;
        logic [31:0] window_start_ms;
        logic [31:0] window_end_ms;
    } cfg_t;

    // Code map write request
    typedef struct packed {
        logic       en;
        logic [7:0] code;
        logic [7:0] data;
    } map_wr_t;

endpackage

>>> rtl/ocew_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPL capture event window - stream interfaces
// Valid/ready channels for command pairs in and register-write events out.
// ----------------------------------------------------------------------------
interface ocew_in_if import ocew_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] code_byte;
    logic [7:0] value_byte;

    modport source (output valid, command, code_byte, value_byte, input ready);
    modport sink   (input valid, command, code_byte, value_byte, output ready);
endinterface

interface ocew_out_if import ocew_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] event_index;
    logic [31:0] time_ms;
    logic [8:0]  register_number;
    logic [7:0]  data_value;
    logic        is_key_register;
    logic        key_on;

    modport source (output valid, event_index, time_ms, register_number, data_value,
                    is_key_register, key_on, input ready);
    modport sink   (input valid, event_index, time_ms, register_number, data_value,
                    is_key_register, key_on, output ready);
endinterface

>>> rtl/ocew_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPL capture event window - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ocew_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/ocew_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPL capture event window - configuration registers
// APB-style register file for delay codes and the time window.
// ----------------------------------------------------------------------------
module ocew_cfg_regs import ocew_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);
    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    cfg_reg_idx_t reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = cfg_reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SHORT_DELAY:  cfg_next.short_delay_code = pwdata[7:0];
                REG_LONG_DELAY:   cfg_next.long_delay_code  = pwdata[7:0];
                REG_WINDOW_START: cfg_next.window_start_ms  = pwdata;
                REG_WINDOW_END:   cfg_next.window_end_ms    = pwdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_delay_code <= SHORT_DELAY_RST;
            cfg_reg.long_delay_code  <= LONG_DELAY_RST;
            cfg_reg.window_start_ms  <= WINDOW_START_RST;
            cfg_reg.window_end_ms    <= WINDOW_END_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read decode
    always_comb
    begin
        unique case (reg_idx)
            REG_SHORT_DELAY:  prdata = {24'd0, cfg_reg.short_delay_code};
            REG_LONG_DELAY:   prdata = {24'd0, cfg_reg.long_delay_code};
            REG_WINDOW_START: prdata = cfg_reg.window_start_ms;
            REG_WINDOW_END:   prdata = cfg_reg.window_end_ms;
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;
endmodule

>>> rtl/ocew_code_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPL capture event window - code map
// Code-to-register map in RAM with per-entry valid bits (cleared at reset)
// and a bypass for a load that lands in the same cycle as a read.
// ----------------------------------------------------------------------------
module ocew_code_map import ocew_pkg::*; #(
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [MAP_IDX_W-1:0] rd_idx,
    input  map_wr_t              map_wr,
    output logic [7:0]           rd_data
);
    localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    logic [MAP_ENTRIES-1:0] vld_reg;
    logic                   rd_vld_reg;
    logic                   rd_inrange_reg;
    logic                   byp_reg;
    logic [7:0]             byp_data_reg;
    logic [7:0]             ram_rdata;
    logic                   wr_inrange;
    logic                   rd_inrange;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   hit;

    assign wr_inrange = map_wr.code < 8'(MAP_ENTRIES);
    assign rd_inrange = {1'b0, rd_idx} < 8'(MAP_ENTRIES);
    assign wr_en      = map_wr.en && wr_inrange;
    assign wr_addr    = map_wr.code[AW-1:0];
    assign rd_addr    = AW'(rd_idx);
    assign hit        = wr_en && rd_inrange && (wr_addr == rd_addr);

    ocew_ram #(
        .WIDTH (8),
        .DEPTH (MAP_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (map_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Entry valid bits: unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Read side flags, captured with the RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg     <= 1'b0;
            rd_inrange_reg <= 1'b0;
            byp_reg        <= 1'b0;
        end
        else if (rd_en)
        begin
            rd_vld_reg     <= rd_inrange && vld_reg[rd_addr];
            rd_inrange_reg <= rd_inrange;
            byp_reg        <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= map_wr.data;
        end
    end

    // Resolve bypass, valid and range
    always_comb
    begin
        if (!rd_inrange_reg)
        begin
            rd_data = 8'd0;
        end
        else if (byp_reg)
        begin
            rd_data = byp_data_reg;
        end
        else if (rd_vld_reg)
        begin
            rd_data = ram_rdata;
        end
        else
        begin
            rd_data = 8'd0;
        end
    end
endmodule

>>> rtl/opl_capture_event_window_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPL capture event window - top level
// Decodes code/value pairs of a captured OPL stream into timed register
// write events inside a configured time window.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_stream carries one transaction per load or stream pair; event_stream
//   carries one transaction per register write that falls in the window.
//   Registers are to be written over the APB-style port only while the
//   block is idle; the block itself does not enforce this. An item is
//   registered on acceptance (code map read issued in the same cycle)
//   and decoded in the decode stage; when that stage advances, its event
//   is loaded into the result register, which drives event_stream.valid.
//   One item is accepted per cycle while the receiver does not stall; the
//   running time add and the code map RAM read are the only per-item
//   dependencies. When the receiver stalls with an event pending, the
//   decode stage holds and cmd_stream.ready drops once it is occupied.
//   Reset clears time, write count, stop flag, all map valid bits (so every
//   map entry reads zero) and restores register defaults; no clearing pass.
//   After a write finds the time past window_end_ms, every item is
//   accepted and dropped until reset.
// ----------------------------------------------------------------------------
module opl_capture_event_window_top import ocew_pkg::*; #(
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ocew_in_if.sink               cmd_stream,
    ocew_out_if.source            event_stream,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);
    cfg_t        cfg;
    map_wr_t     map_wr;
    logic [7:0]  map_data;
    logic        accept;

    // Decode stage registers
    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [7:0]  s1_code_reg;
    logic [7:0]  s1_val_reg;

    // Block state
    logic [31:0] elapsed_reg;
    logic [31:0] elapsed_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic        stopped_reg;
    logic        stopped_next;

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_index_reg;
    logic [31:0] out_time_reg;
    logic [8:0]  out_regnum_reg;
    logic [7:0]  out_data_reg;
    logic        out_key_reg_reg;
    logic        out_key_on_reg;

    // Decode signals
    logic        s1_adv;
    logic        live;
    logic        is_short;
    logic        is_long;
    logic        is_write;
    logic        past_end;
    logic        before_start;
    logic        emit;
    logic [8:0]  val_p1;
    logic [31:0] delay_add;
    logic        key_reg;

    ocew_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ocew_code_map #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (cmd_stream.code_byte[MAP_IDX_W-1:0]),
        .map_wr  (map_wr),
        .rd_data (map_data)
    );

    // Handshake
    assign s1_adv           = s1_valid_reg && (!out_valid_reg || event_stream.ready);
    assign cmd_stream.ready = !s1_valid_reg || s1_adv;
    assign accept           = cmd_stream.valid && cmd_stream.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_stream.ready)
        begin
            s1_valid_reg <= cmd_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd_stream.command;
            s1_code_reg <= cmd_stream.code_byte;
            s1_val_reg  <= cmd_stream.value_byte;
        end
    end

    // Classify the item
    assign live     = s1_adv && !stopped_reg;
    assign is_short = (s1_cmd_reg != CMD_LOAD) && (s1_code_reg == cfg.short_delay_code);
    assign is_long  = (s1_cmd_reg != CMD_LOAD) && !is_short
                      && (s1_code_reg == cfg.long_delay_code);
    assign is_write = (s1_cmd_reg != CMD_LOAD) && !is_short && !is_long;

    assign map_wr.en   = live && (s1_cmd_reg == CMD_LOAD);
    assign map_wr.code = s1_code_reg;
    assign map_wr.data = s1_val_reg;

    // Delay: value+1 ms, or (value+1)*256 ms
    assign val_p1    = {1'b0, s1_val_reg} + 9'd1;
    assign delay_add = is_short ? {23'd0, val_p1} : {15'd0, val_p1, 8'd0};

    assign past_end     = elapsed_reg > cfg.window_end_ms;
    assign before_start = elapsed_reg < cfg.window_start_ms;
    assign emit         = live && is_write && !past_end && !before_start;
    assign key_reg      = map_data[7:4] == KEY_REG_NIBBLE;

    // State update
    always_comb
    begin
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        if (live && (is_short || is_long))
        begin
            elapsed_next = elapsed_reg + delay_add;
        end
        if (live && is_write)
        begin
            if (past_end)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (event_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_index_reg   <= count_reg;
            out_time_reg    <= elapsed_reg;
            out_regnum_reg  <= {s1_code_reg[7], map_data};
            out_data_reg    <= s1_val_reg;
            out_key_reg_reg <= key_reg;
            out_key_on_reg  <= key_reg && s1_val_reg[KEY_ON_BIT];
        end
    end

    assign event_stream.valid           = out_valid_reg;
    assign event_stream.event_index     = out_index_reg;
    assign event_stream.time_ms         = out_time_reg;
    assign event_stream.register_number = out_regnum_reg;
    assign event_stream.data_value      = out_data_reg;
    assign event_stream.is_key_register = out_key_reg_reg;
    assign event_stream.key_on          = out_key_on_reg;

    // Once stopped, the block stays stopped and emits nothing
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg && !emit)
        else $error("stop flag cleared or event emitted after stop");

    // Write count advances by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 32'd1))
        else $error("write count jumped");

    // A stalled pending event blocks the decode stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !event_stream.ready) |-> !s1_adv && !emit)
        else $error("decode advanced into a stalled result register");
endmodule

>>> bench/opl_capture_event_window_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPL capture event window - self-checking testbench
// Drives load and stream-pair transactions into the decoder, predicts every
// register-write event with a cycle-free model of the decode rules, and
// compares each event field by field. Covers map loads, both delay codes,
// window edges, runs of long delays, the empty window and the stop
// condition, with random stalls on both streams.
// ----------------------------------------------------------------------------
module opl_capture_event_window_top_tb;
    import ocew_pkg::*;

    localparam logic CMD_PAIR       = ~CMD_LOAD;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   DRAIN_CYCLES   = 8;

    // One predicted register-write event
    typedef struct packed {
        logic [31:0] event_index;
        logic [31:0] time_ms;
        logic [8:0]  register_number;
        logic [7:0]  data_value;
        logic        is_key_register;
        logic        key_on;
    } wr_event_t;

    logic clk;
    logic rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    ocew_in_if  cmd_if ();
    ocew_out_if ev_if ();

    opl_capture_event_window_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_stream   (cmd_if),
        .event_stream (ev_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Decoder model state
    cfg_t       cur_cfg;
    logic [31:0] run_time;
    logic [31:0] writes_seen;
    logic [7:0]  reg_map [MAP_ENTRIES_DEF];
    bit          halted;

    wr_event_t pending_events[$];

    int src_idle_pct;
    int snk_idle_pct;
    int failures;
    int pairs_sent;
    int events_checked;
    int cfg_writes;
    int quiet_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Model of one accepted transaction; returns 1 when an event is due
    function automatic bit decode_pair(input logic command, input logic [7:0] code,
                                       input logic [7:0] value, output wr_event_t ev);
        logic [8:0] reg_num;
        ev = '0;
        if (halted)
            return 1'b0;
        if (command == CMD_LOAD)
        begin
            if (code < MAP_ENTRIES_DEF)
                reg_map[code] = value;
            return 1'b0;
        end
        if (code == cur_cfg.short_delay_code)
        begin
            run_time += 32'(value) + 32'd1;
            return 1'b0;
        end
        if (code == cur_cfg.long_delay_code)
        begin
            run_time += (32'(value) + 32'd1) << 8;
            return 1'b0;
        end
        if (run_time > cur_cfg.window_end_ms)
        begin
            halted = 1'b1;
            return 1'b0;
        end
        if (run_time < cur_cfg.window_start_ms)
        begin
            writes_seen += 32'd1;
            return 1'b0;
        end
        reg_num = {code[7], reg_map[code[6:0]]};
        ev.event_index     = writes_seen;
        ev.time_ms         = run_time;
        ev.register_number = reg_num;
        ev.data_value      = value;
        ev.is_key_register = (reg_num[7:4] == KEY_REG_NIBBLE);
        ev.key_on          = ev.is_key_register & value[KEY_ON_BIT];
        writes_seen += 32'd1;
        return 1'b1;
    endfunction

    function automatic logic [31:0] clip_add(input logic [31:0] base,
                                             input longint unsigned delta);
        longint unsigned sum;
        sum = longint'(base) + delta;
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Send one transaction, with random idle cycles ahead of it
    task automatic send_pair(input logic command, input logic [7:0] code,
                             input logic [7:0] value);
        wr_event_t ev;
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= command;
        cmd_if.code_byte  <= code;
        cmd_if.value_byte <= value;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        pairs_sent++;
        if (decode_pair(command, code, value, ev))
            pending_events.push_back(ev);
    endtask

    // Stop sending and let all outstanding events drain
    task automatic wait_quiet();
        cmd_if.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_register(input cfg_reg_idx_t idx, input logic [31:0] value);
        wait_quiet();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SHORT_DELAY:  cur_cfg.short_delay_code = value[7:0];
            REG_LONG_DELAY:   cur_cfg.long_delay_code  = value[7:0];
            REG_WINDOW_START: cur_cfg.window_start_ms  = value;
            REG_WINDOW_END:   cur_cfg.window_end_ms    = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            failures++;
        end
    endfunction

    // Event checker and receiver stalls
    always @(posedge clk)
    begin
        wr_event_t exp_ev;
        if (rst_n && ev_if.valid && ev_if.ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event transaction with no event expected");
                failures++;
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                check_field("event_index", exp_ev.event_index, ev_if.event_index);
                check_field("time_ms", exp_ev.time_ms, ev_if.time_ms);
                check_field("register_number", 32'(exp_ev.register_number),
                            32'(ev_if.register_number));
                check_field("data_value", 32'(exp_ev.data_value), 32'(ev_if.data_value));
                check_field("is_key_register", 32'(exp_ev.is_key_register),
                            32'(ev_if.is_key_register));
                check_field("key_on", 32'(exp_ev.key_on), 32'(ev_if.key_on));
                events_checked++;
            end
        end
        ev_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_if.valid && cmd_if.ready) || (ev_if.valid && ev_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transaction", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Map loads, including out-of-range indexes, then writes through them
    task automatic test_map_loads();
        send_pair(CMD_LOAD, 8'd0,   8'hB5);
        send_pair(CMD_LOAD, 8'd127, 8'hBF);
        send_pair(CMD_LOAD, 8'd5,   8'hA0);
        send_pair(CMD_LOAD, 8'd64,  8'hFF);
        send_pair(CMD_LOAD, 8'd128, 8'h12);   // ignored, must not alias entry 0
        send_pair(CMD_LOAD, 8'd255, 8'h34);   // ignored
        send_pair(CMD_PAIR, 8'h80, 8'h20);    // upper bank, key on
        send_pair(CMD_PAIR, 8'hFF, 8'hDF);    // upper bank, key off
        send_pair(CMD_PAIR, 8'h05, 8'hFF);    // not a key register
        send_pair(CMD_PAIR, 8'h40, 8'h00);
        send_pair(CMD_PAIR, 8'h0A, 8'h5A);    // entry never loaded
    endtask

    // Window end at zero while the time is still zero
    task automatic test_window_end_zero();
        write_register(REG_WINDOW_END, 32'h0);
        send_pair(CMD_PAIR, 8'h05, 8'h55);
        write_register(REG_WINDOW_END, 32'hFFFF_FFFF);
    endtask

    // Default delay codes, then both codes equal at 0xFF
    task automatic test_delay_codes();
        send_pair(CMD_PAIR, 8'h00, 8'h00);
        send_pair(CMD_PAIR, 8'h00, 8'hFF);
        send_pair(CMD_PAIR, 8'h01, 8'h00);
        send_pair(CMD_PAIR, 8'h01, 8'hFF);
        send_pair(CMD_PAIR, 8'h40, 8'h11);
        write_register(REG_SHORT_DELAY, 32'hFF);
        write_register(REG_LONG_DELAY, 32'hFF);
        send_pair(CMD_PAIR, 8'hFF, 8'h03);    // equal codes: short delay wins
        send_pair(CMD_PAIR, 8'h01, 8'hAA);    // old long code is now a write
        send_pair(CMD_PAIR, 8'h00, 8'h20);
    endtask

    // Write just before the window start is counted only
    task automatic test_window_start();
        write_register(REG_WINDOW_START, run_time + 32'd1);
        send_pair(CMD_PAIR, 8'h05, 8'h01);
        send_pair(CMD_PAIR, cur_cfg.short_delay_code, 8'h00);
        send_pair(CMD_PAIR, 8'h05, 8'h02);
        write_register(REG_WINDOW_START, 32'h0);
    endtask

    // Back-to-back maximum long delays with writes between them
    task automatic test_long_delays();
        write_register(REG_SHORT_DELAY, 32'h7D);
        write_register(REG_LONG_DELAY, 32'h7E);
        for (int i = 0; i < 32; i++)
        begin
            send_pair(CMD_PAIR, 8'h7E, 8'hFF);
            if (i % 8 == 7)
                send_pair(CMD_PAIR, 8'h85, 8'h3C);
        end
        send_pair(CMD_PAIR, 8'h85, 8'hC3);
    endtask

    // Random traffic with one delay-code setting and window per phase
    task automatic random_phase(input int count, input int src_pct, input int snk_pct,
                                input logic [7:0] short_code, input logic [7:0] long_code,
                                input bit open_end);
        int pick;
        logic [7:0] code;
        logic [7:0] value;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_register(REG_SHORT_DELAY, 32'(short_code));
        write_register(REG_LONG_DELAY, 32'(long_code));
        write_register(REG_WINDOW_START, clip_add(run_time, $urandom_range(0, 3000000)));
        write_register(REG_WINDOW_END, open_end ? 32'hFFFF_FFFF :
                       clip_add(run_time, 64'd400000000 + $urandom_range(0, 1000000)));
        for (int i = 0; i < count; i++)
        begin
            pick  = $urandom_range(99);
            value = 8'($urandom_range(255));
            if (pick < 12)
            begin
                code = ($urandom_range(99) < 85) ? 8'($urandom_range(127))
                                                 : 8'($urandom_range(255, 128));
                if ($urandom_range(99) < 30)
                    value = {KEY_REG_NIBBLE, value[3:0]};
                send_pair(CMD_LOAD, code, value);
            end
            else if (pick < 30)
                send_pair(CMD_PAIR, short_code, value);
            else if (pick < 38)
                send_pair(CMD_PAIR, long_code, value);
            else
                send_pair(CMD_PAIR, 8'($urandom_range(255)), value);
        end
    endtask

    // Start above end: writes are counted, nothing is emitted, no stop
    task automatic test_empty_window();
        write_register(REG_SHORT_DELAY, 32'h7D);
        write_register(REG_LONG_DELAY, 32'h7E);
        write_register(REG_WINDOW_START, 32'hFFFF_FFFF);
        write_register(REG_WINDOW_END, 32'hFFFF_FFFE);
        send_pair(CMD_PAIR, 8'h85, 8'h10);
        send_pair(CMD_PAIR, 8'h7D, 8'h20);
        send_pair(CMD_PAIR, 8'h05, 8'h30);
        write_register(REG_WINDOW_START, 32'h0);
        write_register(REG_WINDOW_END, 32'hFFFF_FFFF);
        send_pair(CMD_PAIR, 8'h85, 8'h40);     // index shows the hidden writes
    endtask

    // Writes at both window edges, then the write that stops the block
    task automatic test_stop();
        write_register(REG_WINDOW_START, run_time);
        write_register(REG_WINDOW_END, run_time + 32'd256);
        send_pair(CMD_PAIR, 8'h85, 8'h21);     // time equals window start
        send_pair(CMD_PAIR, 8'h7D, 8'hFF);
        send_pair(CMD_PAIR, 8'h05, 8'h22);     // time equals window end
        send_pair(CMD_PAIR, 8'h7D, 8'h00);
        send_pair(CMD_PAIR, 8'h05, 8'h23);     // past the end: stops
        for (int i = 0; i < 40; i++)
            send_pair(($urandom_range(1) != 0) ? CMD_PAIR : CMD_LOAD,
                      8'($urandom_range(255)), 8'($urandom_range(255)));
        write_register(REG_WINDOW_END, 32'hFFFF_FFFF);
        send_pair(CMD_LOAD, 8'h05, 8'hB0);
        send_pair(CMD_PAIR, 8'h05, 8'h24);     // still ignored
    endtask

    // Main sequence
    initial
    begin
        cmd_if.valid      <= 1'b0;
        cmd_if.command    <= CMD_LOAD;
        cmd_if.code_byte  <= 8'h00;
        cmd_if.value_byte <= 8'h00;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        rst_n             <= 1'b0;

        cur_cfg.short_delay_code = SHORT_DELAY_RST;
        cur_cfg.long_delay_code  = LONG_DELAY_RST;
        cur_cfg.window_start_ms  = WINDOW_START_RST;
        cur_cfg.window_end_ms    = WINDOW_END_RST;
        run_time    = '0;
        writes_seen = '0;
        halted      = 1'b0;
        foreach (reg_map[i])
            reg_map[i] = '0;
        failures       = 0;
        pairs_sent     = 0;
        events_checked = 0;
        cfg_writes     = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 9;
        snk_idle_pct   = 76;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_map_loads();
        test_window_end_zero();
        test_delay_codes();
        test_window_start();
        test_long_delays();
        random_phase(700, 9, 76, 8'h00, 8'hFF, 1'b1);
        random_phase(650, 76, 9, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
        random_phase(650, 0, 0, 8'hFF, 8'h00, 1'b0);
        test_empty_window();
        test_stop();

        // Drain
        cmd_if.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            $error("%0d expected events never arrived", pending_events.size());
            failures++;
        end

        $display("Run covered %0d input transactions and %0d register writes",
                 pairs_sent, cfg_writes);
        $display("%0d events checked across map, delay, window, long delay and stop cases",
                 events_checked);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
